/* hdl/vfd_pkg.sv */
// Shared types and constants for the display link frame sender.
package vfd_pkg;

    typedef logic [2:0] op_code_t;
    typedef logic [2:0] res_sel_t;
    typedef logic [1:0] byte_sel_t;

    localparam op_code_t OP_SET_DIGIT  = 3'd0;
    localparam op_code_t OP_READ_DIGIT = 3'd1;
    localparam op_code_t OP_BRIGHTNESS = 3'd2;
    localparam op_code_t OP_ENABLE     = 3'd3;
    localparam op_code_t OP_UPDATE     = 3'd4;
    localparam op_code_t OP_RAW        = 3'd5;

    localparam res_sel_t SEL_NONE       = 3'd0;
    localparam res_sel_t SEL_READ       = 3'd1;
    localparam res_sel_t SEL_CTRL       = 3'd2;
    localparam res_sel_t SEL_RAW        = 3'd3;
    localparam res_sel_t SEL_DATA_WRITE = 3'd4;
    localparam res_sel_t SEL_ADDR_SET   = 3'd5;
    localparam res_sel_t SEL_GRID       = 3'd6;

    localparam byte_sel_t BYTE_LO  = 2'd0;
    localparam byte_sel_t BYTE_MID = 2'd1;
    localparam byte_sel_t BYTE_HI  = 2'd2;

    localparam logic [7:0] CMD_DISP_CTRL  = 8'h80;
    localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
    localparam logic [7:0] CMD_ADDR_SET   = 8'hC0;
    localparam logic [7:0] DIM_MAX        = 8'h07;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  position;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic        is_read;
        logic [7:0]  serial_byte;
        logic        frame_start;
        logic        frame_end;
        logic [31:0] read_data;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic     load_item;
        logic     write_digit;
        logic     upd_nibble;
        logic     emit;
        logic     clr_cnt;
        logic     adv_cnt;
        res_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        op_code_t op;
        logic     out_free;
        logic     grid_done;
    } dp_status_t;

endpackage

/* hdl/vfd_grid_frame_sender.sv */
// Top level of the display link frame sender: controller plus datapath.
// Set digit emits no result; read, brightness, enable and raw emit one each. Update emits
// a data write byte, an address set byte, then three bytes per grid from the grid store,
// one byte per cycle while the output is free. A stalled output holds the sequence;
// the next item is taken in the idle state.
// Reset (rst_n, async, active low) clears the grid store, control nibble and valid flag.
module vfd_grid_frame_sender #(
    parameter int GRIDS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  vfd_pkg::in_item_t  cmd_item,
    output logic               res_valid,
    input  logic               res_ready,
    output vfd_pkg::out_item_t res_item
);

    vfd_pkg::dp_cmd_t    cmd;
    vfd_pkg::dp_status_t st;

    vfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .st        (st),
        .cmd       (cmd)
    );

    vfd_dp #(
        .GRIDS (GRIDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_item  (cmd_item),
        .cmd       (cmd),
        .st        (st),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

`ifndef SYNTHESIS
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("item accepted while previous item still in work");

    a_read_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.is_read) |->
            (res_item.last && res_item.serial_byte == 8'd0 && !res_item.frame_start))
        else $error("read result malformed");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.last && !res_item.is_read) |-> res_item.frame_end)
        else $error("final serial byte does not close its frame");

    a_no_accept_while_busy_output: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_item.is_read && !res_item.frame_start) |->
            (!cmd_ready || res_item.last))
        else $error("idle while update frame still streaming");
`endif

endmodule

/* hdl/vfd_ctrl.sv */
// Controller state machine: sequences each item's operation and update frames.
module vfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  vfd_pkg::dp_status_t st,
    output vfd_pkg::dp_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_ADDR = 2'd2;
    localparam logic [1:0] ST_GRID = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = vfd_pkg::SEL_NONE;
        cmd_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (st.op) inside
                    vfd_pkg::OP_SET_DIGIT:
                    begin
                        cmd.write_digit = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    vfd_pkg::OP_READ_DIGIT:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.sel    = vfd_pkg::SEL_READ;
                            state_next = ST_IDLE;
                        end
                    end
                    vfd_pkg::OP_BRIGHTNESS, vfd_pkg::OP_ENABLE:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit       = 1'b1;
                            cmd.upd_nibble = 1'b1;
                            cmd.sel        = vfd_pkg::SEL_CTRL;
                            state_next     = ST_IDLE;
                        end
                    end
                    vfd_pkg::OP_RAW:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.sel    = vfd_pkg::SEL_RAW;
                            state_next = ST_IDLE;
                        end
                    end
                    vfd_pkg::OP_UPDATE:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit    = 1'b1;
                            cmd.clr_cnt = 1'b1;
                            cmd.sel     = vfd_pkg::SEL_DATA_WRITE;
                            state_next  = ST_ADDR;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ADDR:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = vfd_pkg::SEL_ADDR_SET;
                    state_next = ST_GRID;
                end
            end
            ST_GRID:
            begin
                if (st.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.adv_cnt = 1'b1;
                    cmd.sel     = vfd_pkg::SEL_GRID;
                    if (st.grid_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/vfd_dp.sv */
// Datapath: item register, grid store, control nibble, counters and result register.
module vfd_dp #(
    parameter int GRIDS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vfd_pkg::in_item_t    cmd_item,
    input  vfd_pkg::dp_cmd_t     cmd,
    output vfd_pkg::dp_status_t  st,
    output logic                 res_valid,
    input  logic                 res_ready,
    output vfd_pkg::out_item_t   res_item
);

    localparam int GRID_W = (GRIDS > 1) ? $clog2(GRIDS) : 1;

    vfd_pkg::in_item_t   item_reg;
    logic [31:0]         store_reg [0:GRIDS-1];
    logic [3:0]          nibble_reg;
    logic [3:0]          nibble_next;
    logic [GRID_W-1:0]   grid_reg;
    vfd_pkg::byte_sel_t  byte_reg;
    logic                res_valid_reg;
    vfd_pkg::out_item_t  res_item_reg;
    vfd_pkg::out_item_t  res_next;
    logic                in_range;
    logic [GRID_W-1:0]   pos_idx;
    logic [GRID_W-1:0]   rd_idx;
    logic [31:0]         rd_word;
    logic [2:0]          dim;
    logic                grid_done;
    logic                out_free;

    assign in_range  = item_reg.position < 8'(GRIDS);
    assign pos_idx   = item_reg.position[GRID_W-1:0];
    assign rd_idx    = (cmd.sel == vfd_pkg::SEL_GRID) ? grid_reg : pos_idx;
    assign rd_word   = store_reg[rd_idx];
    assign grid_done = (grid_reg == GRID_W'(GRIDS - 1)) && (byte_reg == vfd_pkg::BYTE_HI);
    assign out_free  = !res_valid_reg || res_ready;

    assign st.op        = item_reg.op;
    assign st.out_free  = out_free;
    assign st.grid_done = grid_done;

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    assign dim = (item_reg.value[7:0] > vfd_pkg::DIM_MAX) ? vfd_pkg::DIM_MAX[2:0]
                                                          : item_reg.value[2:0];

    always_comb
    begin
        case (item_reg.op)
            vfd_pkg::OP_BRIGHTNESS: nibble_next = {nibble_reg[3], dim};
            vfd_pkg::OP_ENABLE:     nibble_next = {|item_reg.value, nibble_reg[2:0]};
            default:                nibble_next = nibble_reg;
        endcase
    end

    always_comb
    begin
        res_next = '0;
        case (cmd.sel)
            vfd_pkg::SEL_READ:
            begin
                res_next.is_read   = 1'b1;
                res_next.read_data = in_range ? rd_word : 32'd0;
                res_next.last      = 1'b1;
            end
            vfd_pkg::SEL_CTRL:
            begin
                res_next.serial_byte = vfd_pkg::CMD_DISP_CTRL | {4'd0, nibble_next};
                res_next.frame_start = 1'b1;
                res_next.frame_end   = 1'b1;
                res_next.last        = 1'b1;
            end
            vfd_pkg::SEL_RAW:
            begin
                res_next.serial_byte = item_reg.value[7:0];
                res_next.frame_start = 1'b1;
                res_next.frame_end   = 1'b1;
                res_next.last        = 1'b1;
            end
            vfd_pkg::SEL_DATA_WRITE:
            begin
                res_next.serial_byte = vfd_pkg::CMD_DATA_WRITE;
                res_next.frame_start = 1'b1;
                res_next.frame_end   = 1'b1;
            end
            vfd_pkg::SEL_ADDR_SET:
            begin
                res_next.serial_byte = vfd_pkg::CMD_ADDR_SET;
                res_next.frame_start = 1'b1;
            end
            vfd_pkg::SEL_GRID:
            begin
                case (byte_reg)
                    vfd_pkg::BYTE_LO:  res_next.serial_byte = rd_word[7:0];
                    vfd_pkg::BYTE_MID: res_next.serial_byte = rd_word[15:8];
                    default:           res_next.serial_byte = {4'd0, rd_word[19:16]};
                endcase
                res_next.frame_end = grid_done;
                res_next.last      = grid_done;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= cmd_item;
        end
        if (cmd.emit)
        begin
            res_item_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GRIDS; i++)
            begin
                store_reg[i] <= 32'd0;
            end
            nibble_reg    <= 4'd0;
            grid_reg      <= '0;
            byte_reg      <= vfd_pkg::BYTE_LO;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_digit && in_range)
            begin
                store_reg[pos_idx] <= item_reg.value;
            end
            if (cmd.upd_nibble)
            begin
                nibble_reg <= nibble_next;
            end
            if (cmd.clr_cnt)
            begin
                grid_reg <= '0;
                byte_reg <= vfd_pkg::BYTE_LO;
            end
            else if (cmd.adv_cnt)
            begin
                if (byte_reg == vfd_pkg::BYTE_HI)
                begin
                    byte_reg <= vfd_pkg::BYTE_LO;
                    grid_reg <= grid_reg + GRID_W'(1);
                end
                else
                begin
                    byte_reg <= byte_reg + 2'd1;
                end
            end
            if (cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the display link frame sender: random traffic, scoreboard check.
module testbench;

    localparam int GRIDS = 16;
    localparam int CTRL_ON_BIT = 3;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 200;
    localparam int PRESSURE_CYCLES = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam vfd_pkg::op_code_t OP_UNUSED_LO = 3'd6;
    localparam vfd_pkg::op_code_t OP_UNUSED_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    vfd_pkg::in_item_t cmd_item = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    vfd_pkg::out_item_t res_item;

    logic cmd_accepted = 1'b0;
    vfd_pkg::in_item_t pending_cmds[$];
    int unsigned pending_gaps[$];
    vfd_pkg::out_item_t expected_link_out[$];

    logic [31:0] grid_words [GRIDS];
    logic [3:0] ctrl_nibble;

    int unsigned idle_left = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned free_left = 0;
    int unsigned pressure_stage = 0;
    int unsigned cmd_count = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;

    vfd_grid_frame_sender #(
        .GRIDS(GRIDS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_item(cmd_item),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_item(res_item)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void push_serial(logic [7:0] data_byte, logic starts, logic closes,
                                        logic final_item);
        vfd_pkg::out_item_t r;
        r = '0;
        r.serial_byte = data_byte;
        r.frame_start = starts;
        r.frame_end = closes;
        r.last = final_item;
        expected_link_out.push_back(r);
    endfunction

    function automatic void predict_link_output(vfd_pkg::in_item_t cmd);
        vfd_pkg::out_item_t r;
        logic [7:0] level;
        logic [31:0] w;
        r = '0;
        case (cmd.op)
            vfd_pkg::OP_SET_DIGIT:
            begin
                if (cmd.position < GRIDS)
                    grid_words[cmd.position] = cmd.value;
            end
            vfd_pkg::OP_READ_DIGIT:
            begin
                r.is_read = 1'b1;
                r.read_data = (cmd.position < GRIDS) ? grid_words[cmd.position]
                                                     : 32'h0;
                r.last = 1'b1;
                expected_link_out.push_back(r);
            end
            vfd_pkg::OP_BRIGHTNESS:
            begin
                level = (cmd.value[7:0] > vfd_pkg::DIM_MAX) ? vfd_pkg::DIM_MAX
                                                            : cmd.value[7:0];
                ctrl_nibble = {ctrl_nibble[CTRL_ON_BIT], level[2:0]};
                push_serial(vfd_pkg::CMD_DISP_CTRL | {4'h0, ctrl_nibble}, 1'b1, 1'b1, 1'b1);
            end
            vfd_pkg::OP_ENABLE:
            begin
                ctrl_nibble[CTRL_ON_BIT] = (cmd.value != 32'h0);
                push_serial(vfd_pkg::CMD_DISP_CTRL | {4'h0, ctrl_nibble}, 1'b1, 1'b1, 1'b1);
            end
            vfd_pkg::OP_UPDATE:
            begin
                push_serial(vfd_pkg::CMD_DATA_WRITE, 1'b1, 1'b1, 1'b0);
                push_serial(vfd_pkg::CMD_ADDR_SET, 1'b1, 1'b0, 1'b0);
                for (int g = 0; g < GRIDS; g++)
                begin
                    w = grid_words[g];
                    push_serial(w[7:0], 1'b0, 1'b0, 1'b0);
                    push_serial(w[15:8], 1'b0, 1'b0, 1'b0);
                    push_serial({4'h0, w[19:16]}, 1'b0, g == GRIDS - 1, g == GRIDS - 1);
                end
            end
            vfd_pkg::OP_RAW:
            begin
                push_serial(cmd.value[7:0], 1'b1, 1'b1, 1'b1);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic compare_link_output(vfd_pkg::out_item_t got, vfd_pkg::out_item_t want);
        if (got.is_read !== want.is_read)
        begin
            $error("is_read: expected %0d, got %0d", want.is_read, got.is_read);
            error_count++;
        end
        if (got.serial_byte !== want.serial_byte)
        begin
            $error("serial_byte: expected %02h, got %02h", want.serial_byte, got.serial_byte);
            error_count++;
        end
        if (got.frame_start !== want.frame_start)
        begin
            $error("frame_start: expected %0d, got %0d", want.frame_start, got.frame_start);
            error_count++;
        end
        if (got.frame_end !== want.frame_end)
        begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
            error_count++;
        end
        if (got.read_data !== want.read_data)
        begin
            $error("read_data: expected %08h, got %08h", want.read_data, got.read_data);
            error_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            error_count++;
        end
    endtask

    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic vfd_pkg::in_item_t make_cmd(vfd_pkg::op_code_t op,
                                                   logic [7:0] position,
                                                   logic [31:0] value);
        vfd_pkg::in_item_t cmd;
        cmd.op = op;
        cmd.position = position;
        cmd.value = value;
        return cmd;
    endfunction

    function automatic vfd_pkg::in_item_t make_random_cmd();
        vfd_pkg::in_item_t cmd;
        int unsigned r;
        r = $urandom_range(0, 99);
        cmd.value = $urandom;
        if ($urandom_range(0, 9) < 7)
            cmd.position = 8'($urandom_range(0, GRIDS - 1));
        else
            cmd.position = 8'($urandom);
        if (r < 28)
            cmd.op = vfd_pkg::OP_SET_DIGIT;
        else if (r < 48)
            cmd.op = vfd_pkg::OP_READ_DIGIT;
        else if (r < 58)
        begin
            cmd.op = vfd_pkg::OP_BRIGHTNESS;
            if ($urandom_range(0, 1) == 1)
                cmd.value[7:0] = 8'($urandom_range(0, 9));
        end
        else if (r < 68)
        begin
            cmd.op = vfd_pkg::OP_ENABLE;
            if ($urandom_range(0, 1) == 1)
                cmd.value = 32'h0;
        end
        else if (r < 80)
            cmd.op = vfd_pkg::OP_RAW;
        else if (r < 94)
            cmd.op = vfd_pkg::OP_UPDATE;
        else if (r < 97)
            cmd.op = OP_UNUSED_LO;
        else
            cmd.op = OP_UNUSED_HI;
        return cmd;
    endfunction

    task automatic queue_cmd(vfd_pkg::in_item_t cmd, int unsigned gap);
        pending_cmds.push_back(cmd);
        pending_gaps.push_back(gap);
    endtask

    // sender: idle for each item's gap, then hold the item until accepted
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (cmd_valid && !cmd_accepted)
        begin
        end
        else if (idle_left > 0)
        begin
            idle_left--;
            cmd_valid <= 1'b0;
        end
        else if (pending_cmds.size() != 0 && pending_gaps[0] != 0)
        begin
            idle_left = pending_gaps[0] - 1;
            pending_gaps[0] = 0;
            cmd_valid <= 1'b0;
        end
        else if (pending_cmds.size() != 0)
        begin
            cmd_item <= pending_cmds.pop_front();
            void'(pending_gaps.pop_front());
            cmd_valid <= 1'b1;
        end
        else
            cmd_valid <= 1'b0;
    end

    // receiver: random stalls, free-running stretches, long hold-offs
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else if ((pressure_stage == 0 && cmd_count >= 60) ||
                 (pressure_stage == 1 && cmd_count >= 170))
        begin
            pressure_stage++;
            hold_left = PRESSURE_CYCLES - 1;
            res_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_ready <= 1'b0;
        end
        else if (free_left > 0)
        begin
            free_left--;
            res_ready <= 1'b1;
        end
        else
        begin
            case ($urandom_range(0, 99)) inside
                [0:2]:
                begin
                    free_left = $urandom_range(50, 200);
                    res_ready <= 1'b1;
                end
                [3:69]:
                    res_ready <= 1'b1;
                [70:94]:
                begin
                    stall_left = $urandom_range(0, 2);
                    res_ready <= 1'b0;
                end
                default:
                begin
                    stall_left = $urandom_range(14, 49);
                    res_ready <= 1'b0;
                end
            endcase
        end
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                predict_link_output(cmd_item);
                cmd_count++;
            end
            if (res_valid && res_ready)
            begin
                if (expected_link_out.size() == 0)
                begin
                    $error("unexpected result: serial_byte %02h, read_data %08h",
                           res_item.serial_byte, res_item.read_data);
                    error_count++;
                end
                else
                    compare_link_output(res_item, expected_link_out.pop_front());
            end
        end
        cmd_accepted <= rst_n && cmd_valid && cmd_ready;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int g = 0; g < GRIDS; g++)
            grid_words[g] = 32'h0;
        ctrl_nibble = 4'h0;

        queue_cmd(make_cmd(vfd_pkg::OP_READ_DIGIT, 8'd0, 32'h0), 0);
        queue_cmd(make_cmd(vfd_pkg::OP_UPDATE, 8'd0, 32'h0), 0);
        queue_cmd(make_cmd(vfd_pkg::OP_SET_DIGIT, 8'd0, 32'hFFFF_FFFF), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_SET_DIGIT, 8'd15, 32'h0), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_SET_DIGIT, 8'd16, 32'hA5A5_A5A5), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_SET_DIGIT, 8'd255, 32'h5A5A_5A5A), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_SET_DIGIT, 8'd7, 32'h000F_1234), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_READ_DIGIT, 8'd0, 32'h0), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_READ_DIGIT, 8'd15, 32'hFFFF_FFFF), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_READ_DIGIT, 8'd16, 32'h0), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_READ_DIGIT, 8'd255, 32'h0), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_BRIGHTNESS, 8'd0, 32'h0), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_BRIGHTNESS, 8'd0, 32'h7), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_BRIGHTNESS, 8'd0, 32'h8), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_ENABLE, 8'd0, 32'h1), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_BRIGHTNESS, 8'hFF, 32'hFFFF_FFFF), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_BRIGHTNESS, 8'd0, 32'h0000_0100), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_ENABLE, 8'd0, 32'h8000_0000), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_ENABLE, 8'd0, 32'h0), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_RAW, 8'd0, 32'h0), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_RAW, 8'd0, 32'hFFFF_FF5A), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_RAW, 8'd0, 32'h0000_00FF), pick_gap(0));
        queue_cmd(make_cmd(OP_UNUSED_LO, 8'd3, 32'hFFFF_FFFF), pick_gap(0));
        queue_cmd(make_cmd(OP_UNUSED_HI, 8'hFF, 32'hFFFF_FFFF), pick_gap(0));
        queue_cmd(make_cmd(vfd_pkg::OP_UPDATE, 8'd0, 32'h0), pick_gap(0));
        for (int i = 0; i < RANDOM_ITEMS; i++)
            queue_cmd(make_random_cmd(), pick_gap(i >= 90 && i < 130));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_valid)
            @(posedge clk);
        while (expected_link_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hdl/vfd_pkg.sv
hdl/vfd_ctrl.sv
hdl/vfd_dp.sv
hdl/vfd_grid_frame_sender.sv
tb/testbench.sv
